// ===== rtl/core/mvb_pkg.sv =====
// shared types, constants and functions of the mavlink v2 frame builder
`timescale 1ns / 1ps

package mvb_pkg;

    localparam logic [7:0]  MAGIC_V2    = 8'hFD;
    localparam logic [15:0] CRC_SEED    = 16'hFFFF;
    localparam int          EXTRA_COUNT = 100;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    localparam logic REG_SYS_ID  = 1'b0;
    localparam logic REG_COMP_ID = 1'b1;

    typedef struct packed {
        logic [7:0] sys_id;
        logic [7:0] comp_id;
    } cfg_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
        logic       stray_byte;
        logic       last_of_run;
    } res_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        crc_step = {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
                 ^ {12'h000, t[7:4]};
    endfunction

    function automatic logic [7:0] crc_extra(input logic [23:0] id);
        logic [6:0] idx;
        idx = (id < 24'(EXTRA_COUNT)) ? id[6:0] : 7'd0;
        case (idx)
            7'd0:    crc_extra = 8'd50;
            7'd1:    crc_extra = 8'd124;
            7'd2:    crc_extra = 8'd137;
            7'd4:    crc_extra = 8'd237;
            7'd5:    crc_extra = 8'd217;
            7'd6:    crc_extra = 8'd104;
            7'd7:    crc_extra = 8'd119;
            7'd11:   crc_extra = 8'd89;
            7'd20:   crc_extra = 8'd214;
            7'd21:   crc_extra = 8'd159;
            7'd22:   crc_extra = 8'd220;
            7'd23:   crc_extra = 8'd168;
            7'd24:   crc_extra = 8'd24;
            7'd25:   crc_extra = 8'd23;
            7'd26:   crc_extra = 8'd170;
            7'd27:   crc_extra = 8'd144;
            7'd28:   crc_extra = 8'd67;
            7'd29:   crc_extra = 8'd115;
            7'd30:   crc_extra = 8'd39;
            7'd31:   crc_extra = 8'd246;
            7'd32:   crc_extra = 8'd185;
            7'd33:   crc_extra = 8'd104;
            7'd34:   crc_extra = 8'd237;
            7'd35:   crc_extra = 8'd244;
            7'd36:   crc_extra = 8'd222;
            7'd37:   crc_extra = 8'd212;
            7'd38:   crc_extra = 8'd9;
            7'd39:   crc_extra = 8'd254;
            7'd40:   crc_extra = 8'd230;
            7'd41:   crc_extra = 8'd28;
            7'd42:   crc_extra = 8'd28;
            7'd43:   crc_extra = 8'd132;
            7'd44:   crc_extra = 8'd221;
            7'd45:   crc_extra = 8'd232;
            7'd46:   crc_extra = 8'd11;
            7'd47:   crc_extra = 8'd153;
            7'd48:   crc_extra = 8'd41;
            7'd49:   crc_extra = 8'd39;
            7'd50:   crc_extra = 8'd78;
            7'd54:   crc_extra = 8'd15;
            7'd55:   crc_extra = 8'd3;
            7'd61:   crc_extra = 8'd153;
            7'd62:   crc_extra = 8'd183;
            7'd63:   crc_extra = 8'd35;
            7'd75:   crc_extra = 8'd90;
            7'd76:   crc_extra = 8'd104;
            7'd77:   crc_extra = 8'd85;
            7'd78:   crc_extra = 8'd95;
            7'd79:   crc_extra = 8'd130;
            7'd83:   crc_extra = 8'd8;
            7'd84:   crc_extra = 8'd204;
            7'd85:   crc_extra = 8'd49;
            7'd86:   crc_extra = 8'd170;
            7'd87:   crc_extra = 8'd44;
            7'd88:   crc_extra = 8'd83;
            7'd89:   crc_extra = 8'd46;
            default: crc_extra = 8'd0;
        endcase
    endfunction

endpackage

// ===== rtl/core/mavlink_v2_frame_builder.sv =====
// top level of the mavlink v2 frame builder: registers, sequencer, output stage
//
// input channel s_*: one item is either a start (tuser 0) carrying payload length
// and message id, or a payload byte (tuser 1). output channel m_*: one frame byte
// per item, tlast on the high checksum byte that closes a frame, tuser flags a
// dropped stray payload byte and the final byte caused by each input item.
// system and component id are written over the apb port; the user must do so only
// while the block is idle, which the block does not enforce. an accepted item passes
// the item and output registers before its first byte shows. the byte sequencer gives
// one output byte per cycle and updates the crc once per byte, so payload bytes not
// closing a frame stream at one item per cycle; a start emits ten bytes (twelve for
// zero length) and a closing payload byte also emits both crc bytes, holding s_tready
// low until the next item is taken with the current one's last byte.
// reset clears the sequence number, crc, open message and both registers.
// when m_tready is low the output register holds its byte and the sequencer waits.
`timescale 1ns / 1ps

module mavlink_v2_frame_builder (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: payload_length[7:0], message_id[31:8], payload_byte[39:32]
    input  logic [39:0] s_tdata,
    // s_tuser: action
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: frame_byte
    output logic [7:0]  m_tdata,
    // m_tlast: end_of_frame
    output logic        m_tlast,
    // m_tuser: stray_byte[0], last_of_run[1]
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mvb_pkg::*;

    cfg_t       cfg;
    res_t       res;
    logic       res_valid;
    logic       take;
    logic       out_valid_reg;
    res_t       out_reg;

    mvb_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mvb_frame_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_length (s_tdata[7:0]),
        .in_id     (s_tdata[31:8]),
        .in_byte   (s_tdata[39:32]),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (take)
    );

    assign take = res_valid && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.frame_byte;
    assign m_tlast  = out_reg.end_of_frame;
    assign m_tuser  = {out_reg.last_of_run, out_reg.stray_byte};

endmodule

// ===== rtl/core/mvb_cfg_regs.sv =====
// apb register file holding system id and component id
`timescale 1ns / 1ps

module mvb_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mvb_pkg::cfg_t     cfg
);
    import mvb_pkg::*;

    logic [7:0] sys_id_reg;
    logic [7:0] comp_id_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_id_reg  <= 8'h00;
            comp_id_reg <= 8'h00;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_SYS_ID:  sys_id_reg  <= pwdata[7:0];
                REG_COMP_ID: comp_id_reg <= pwdata[7:0];
                default:     sys_id_reg  <= sys_id_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SYS_ID:  prdata = {24'h000000, sys_id_reg};
            REG_COMP_ID: prdata = {24'h000000, comp_id_reg};
            default:     prdata = 32'h00000000;
        endcase
    end

    assign cfg.sys_id  = sys_id_reg;
    assign cfg.comp_id = comp_id_reg;

endmodule

// ===== rtl/core/mvb_frame_seq.sv =====
// item register and byte sequencer with running crc for one frame
`timescale 1ns / 1ps

module mvb_frame_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  mvb_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_action,
    input  logic [7:0]        in_length,
    input  logic [23:0]       in_id,
    input  logic [7:0]        in_byte,
    output logic              res_valid,
    output mvb_pkg::res_t     res,
    input  logic              res_take
);
    import mvb_pkg::*;

    localparam logic [3:0] ST_MAGIC  = 4'd0;
    localparam logic [3:0] ST_LEN    = 4'd1;
    localparam logic [3:0] ST_INCOMP = 4'd2;
    localparam logic [3:0] ST_COMPAT = 4'd3;
    localparam logic [3:0] ST_SEQ    = 4'd4;
    localparam logic [3:0] ST_SYS    = 4'd5;
    localparam logic [3:0] ST_COMP   = 4'd6;
    localparam logic [3:0] ST_ID0    = 4'd7;
    localparam logic [3:0] ST_ID1    = 4'd8;
    localparam logic [3:0] ST_ID2    = 4'd9;
    localparam logic [3:0] ST_CRC_LO = 4'd10;
    localparam logic [3:0] ST_CRC_HI = 4'd11;

    localparam logic [3:0] PL_BYTE   = 4'd0;
    localparam logic [3:0] PL_CRC_LO = 4'd1;
    localparam logic [3:0] PL_CRC_HI = 4'd2;

    logic        item_valid_reg;
    logic        item_action_reg;
    logic [7:0]  item_len_reg;
    logic [23:0] item_id_reg;
    logic [7:0]  item_byte_reg;
    logic [3:0]  step_reg;

    logic [7:0]  seq_num_reg,  seq_num_next;
    logic [15:0] crc_reg,      crc_next;
    logic [7:0]  rem_reg,      rem_next;
    logic        open_reg,     open_next;
    logic [7:0]  extra_reg,    extra_next;

    logic [15:0] fin_crc;
    logic        upd;
    logic        accept;
    logic        adv;

    assign fin_crc   = crc_step(crc_reg, extra_reg);
    assign res_valid = item_valid_reg;
    assign adv       = item_valid_reg && res_take;
    assign in_ready  = !item_valid_reg || (adv && res.last_of_run);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        res          = '0;
        upd          = 1'b0;
        seq_num_next = seq_num_reg;
        crc_next     = crc_reg;
        rem_next     = rem_reg;
        open_next    = open_reg;
        extra_next   = extra_reg;
        if (item_action_reg == ACT_START)
        begin
            case (step_reg)
                ST_MAGIC:
                begin
                    res.frame_byte = MAGIC_V2;
                    crc_next       = CRC_SEED;
                    extra_next     = crc_extra(item_id_reg);
                    rem_next       = item_len_reg;
                    open_next      = 1'b1;
                end
                ST_LEN:
                begin
                    res.frame_byte = item_len_reg;
                    upd            = 1'b1;
                end
                ST_INCOMP, ST_COMPAT:
                begin
                    upd = 1'b1;
                end
                ST_SEQ:
                begin
                    res.frame_byte = seq_num_reg;
                    seq_num_next   = seq_num_reg + 8'd1;
                    upd            = 1'b1;
                end
                ST_SYS:
                begin
                    res.frame_byte = cfg.sys_id;
                    upd            = 1'b1;
                end
                ST_COMP:
                begin
                    res.frame_byte = cfg.comp_id;
                    upd            = 1'b1;
                end
                ST_ID0:
                begin
                    res.frame_byte = item_id_reg[7:0];
                    upd            = 1'b1;
                end
                ST_ID1:
                begin
                    res.frame_byte = item_id_reg[15:8];
                    upd            = 1'b1;
                end
                ST_ID2:
                begin
                    res.frame_byte  = item_id_reg[23:16];
                    upd             = 1'b1;
                    res.last_of_run = (item_len_reg != 8'd0);
                end
                ST_CRC_LO:
                begin
                    res.frame_byte = fin_crc[7:0];
                    crc_next       = fin_crc;
                end
                ST_CRC_HI:
                begin
                    res.frame_byte   = crc_reg[15:8];
                    res.end_of_frame = 1'b1;
                    res.last_of_run  = 1'b1;
                    crc_next         = CRC_SEED;
                    open_next        = 1'b0;
                    rem_next         = 8'd0;
                end
                default:
                begin
                    res.last_of_run = 1'b1;
                end
            endcase
        end
        else
        begin
            case (step_reg)
                PL_BYTE:
                begin
                    if (!open_reg)
                    begin
                        res.stray_byte  = 1'b1;
                        res.last_of_run = 1'b1;
                    end
                    else
                    begin
                        res.frame_byte  = item_byte_reg;
                        upd             = 1'b1;
                        rem_next        = rem_reg - 8'd1;
                        res.last_of_run = (rem_reg != 8'd1);
                    end
                end
                PL_CRC_LO:
                begin
                    res.frame_byte = fin_crc[7:0];
                    crc_next       = fin_crc;
                end
                PL_CRC_HI:
                begin
                    res.frame_byte   = crc_reg[15:8];
                    res.end_of_frame = 1'b1;
                    res.last_of_run  = 1'b1;
                    crc_next         = CRC_SEED;
                    open_next        = 1'b0;
                    rem_next         = 8'd0;
                end
                default:
                begin
                    res.last_of_run = 1'b1;
                end
            endcase
        end
        if (upd)
        begin
            crc_next = crc_step(crc_reg, res.frame_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            step_reg       <= 4'd0;
            seq_num_reg    <= 8'h00;
            crc_reg        <= CRC_SEED;
            rem_reg        <= 8'h00;
            open_reg       <= 1'b0;
            extra_reg      <= 8'h00;
        end
        else
        begin
            if (adv)
            begin
                seq_num_reg <= seq_num_next;
                crc_reg     <= crc_next;
                rem_reg     <= rem_next;
                open_reg    <= open_next;
                extra_reg   <= extra_next;
            end
            if (accept)
            begin
                item_valid_reg <= 1'b1;
                step_reg       <= 4'd0;
            end
            else if (adv)
            begin
                item_valid_reg <= !res.last_of_run;
                step_reg       <= step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_action_reg <= in_action;
            item_len_reg    <= in_length;
            item_id_reg     <= in_id;
            item_byte_reg   <= in_byte;
        end
    end

endmodule
